@@ rtl/core/wce_pkg.sv @@
// ----------------------------------------------------------------------------
// wce_pkg
// Shared types, register map and defaults of the waveform column envelope.
// ----------------------------------------------------------------------------
package wce_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COLUMN_BITS_DEF = 12;
    localparam int ROW_BITS_DEF    = 11;
    localparam int QUEUE_DEPTH     = 4;

    localparam int SPC_W  = 16;
    localparam int SW_W   = 13;
    localparam int TH_W   = 12;
    localparam int GAIN_W = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SPC_W-1:0]  SPC_RST  = 16'd1;
    localparam logic [SW_W-1:0]   SW_RST   = 13'd800;
    localparam logic [TH_W-1:0]   TH_RST   = 12'd256;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
    localparam logic              SHOW_RST = 1'b1;

    typedef enum logic [2:0] {
        REG_SPC  = 3'd0,
        REG_SW   = 3'd1,
        REG_TH   = 3'd2,
        REG_GAIN = 3'd3,
        REG_SHOW = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SPC_W-1:0]  samples_per_column;
        logic [SW_W-1:0]   screen_width;
        logic [TH_W-1:0]   track_height;
        logic [GAIN_W-1:0] gain;
        logic              show_clipping;
    } cfg_t;

endpackage

@@ rtl/core/waveform_column_envelope_unit.sv @@
// ----------------------------------------------------------------------------
// waveform_column_envelope_unit
// Min/max peak decimator feeding a scrolling waveform display.
// ----------------------------------------------------------------------------
// The intake takes one sample per clock while the four-entry column queue has
// room, so with samples_per_column of 7 or more the block sustains one sample
// per cycle while results are popped. Each finished column takes the row
// mapper through a fetch, then product, span and row steps for max and then
// min on one shared multiply path; with shorter runs the mapper sets the pace
// and the queue absorbs bursts. A result waits in the output register until
// popped while the next column is mapped. Configuration takes effect at once
// and is meant to be written between streams.
module waveform_column_envelope_unit #(
    parameter int SAMPLE_BITS = wce_pkg::SAMPLE_BITS_DEF,
    parameter int COLUMN_BITS = wce_pkg::COLUMN_BITS_DEF,
    parameter int ROW_BITS    = wce_pkg::ROW_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wce_pkg::ADDR_W-1:0]    paddr,
    input  logic [wce_pkg::DATA_W-1:0]    pwdata,
    output logic [wce_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          pop,
    output logic                          empty,
    output logic [COLUMN_BITS-1:0]        column,
    output logic [ROW_BITS-1:0]           upper_row,
    output logic [ROW_BITS-1:0]           lower_row,
    output logic                          clipped
);
    import wce_pkg::*;

    localparam int ITEM_W = 2 * SAMPLE_BITS + 1 + COLUMN_BITS;

    cfg_t              cfg;
    logic              q_push, q_full, q_pop, q_empty;
    logic [ITEM_W-1:0] q_wdata, q_rdata;

    wce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wce_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .full   (full),
        .sample (sample),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    wce_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    wce_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .ROW_BITS    (ROW_BITS),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_pop     (q_pop),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .pop       (pop),
        .empty     (empty),
        .column    (column),
        .upper_row (upper_row),
        .lower_row (lower_row),
        .clipped   (clipped)
    );

endmodule

@@ rtl/core/wce_regs.sv @@
// ----------------------------------------------------------------------------
// wce_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module wce_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wce_pkg::ADDR_W-1:0] paddr,
    input  logic [wce_pkg::DATA_W-1:0] pwdata,
    output logic [wce_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wce_pkg::cfg_t              cfg
);
    import wce_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_column <= SPC_RST;
            cfg_reg.screen_width       <= SW_RST;
            cfg_reg.track_height       <= TH_RST;
            cfg_reg.gain               <= GAIN_RST;
            cfg_reg.show_clipping      <= SHOW_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SPC:  cfg_reg.samples_per_column <= pwdata[SPC_W-1:0];
                REG_SW:   cfg_reg.screen_width       <= pwdata[SW_W-1:0];
                REG_TH:   cfg_reg.track_height       <= pwdata[TH_W-1:0];
                REG_GAIN: cfg_reg.gain               <= pwdata[GAIN_W-1:0];
                REG_SHOW: cfg_reg.show_clipping      <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SPC:  prdata = DATA_W'(cfg_reg.samples_per_column);
            REG_SW:   prdata = DATA_W'(cfg_reg.screen_width);
            REG_TH:   prdata = DATA_W'(cfg_reg.track_height);
            REG_GAIN: prdata = DATA_W'(cfg_reg.gain);
            REG_SHOW: prdata = DATA_W'(cfg_reg.show_clipping);
            default:  prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/wce_front.sv @@
// ----------------------------------------------------------------------------
// wce_front
// Sample intake: folds each run into max, min and clip flag, tracks the
// column index and hands one envelope per run to the column queue.
// ----------------------------------------------------------------------------
module wce_front #(
    parameter int SAMPLE_BITS = wce_pkg::SAMPLE_BITS_DEF,
    parameter int COLUMN_BITS = wce_pkg::COLUMN_BITS_DEF,
    parameter int ITEM_W      = 2 * SAMPLE_BITS + 1 + COLUMN_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wce_pkg::cfg_t                 cfg,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          q_push,
    input  logic                          q_full,
    output logic [ITEM_W-1:0]             q_data
);
    import wce_pkg::*;

    localparam int CNW = (COLUMN_BITS + 1 > SW_W) ? COLUMN_BITS + 1 : SW_W;
    localparam logic signed [SAMPLE_BITS-1:0] FULL_POS =
        {2'b01, {(SAMPLE_BITS-2){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG =
        {2'b11, {(SAMPLE_BITS-2){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] max_reg, min_reg, max_next, min_next;
    logic                          clip_reg, clip_next;
    logic [SPC_W-1:0]              count_reg, count_inc, run_len;
    logic [COLUMN_BITS-1:0]        col_reg, col_next;
    logic [CNW-1:0]                col_inc, width_eff;
    logic                          accept, first, hit, run_end, wrap;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign first = (count_reg == '0);
    assign hit   = (sample >= FULL_POS) || (sample <= FULL_NEG);

    always_comb
    begin
        if (first)
        begin
            max_next = sample;
            min_next = sample;
        end
        else
        begin
            max_next = (sample > max_reg) ? sample : max_reg;
            min_next = (sample < min_reg) ? sample : min_reg;
        end
    end

    assign clip_next = hit || (!first && clip_reg);

    // A run ends once the count reaches or passes the run length, also
    // after the run length was lowered below it; the count never wraps.
    assign count_inc = count_reg + SPC_W'(1);
    assign run_len   = (cfg.samples_per_column == '0) ? SPC_W'(1) : cfg.samples_per_column;
    assign run_end   = (count_inc >= run_len) || (count_inc == '0);

    assign col_inc   = CNW'(col_reg) + CNW'(1);
    assign width_eff = (cfg.screen_width == '0) ? CNW'(1) : CNW'(cfg.screen_width);
    assign wrap      = (col_inc >= width_eff) || col_inc[COLUMN_BITS];
    assign col_next  = wrap ? '0 : col_inc[COLUMN_BITS-1:0];

    assign q_push = accept && run_end;
    assign q_data = {col_reg, clip_next, min_next, max_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            min_reg   <= '0;
            clip_reg  <= 1'b0;
            count_reg <= '0;
            col_reg   <= '0;
        end
        else if (accept)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
            if (run_end)
            begin
                count_reg <= '0;
                clip_reg  <= 1'b0;
                col_reg   <= col_next;
            end
            else
            begin
                count_reg <= count_inc;
                clip_reg  <= clip_next;
            end
        end
    end

endmodule

@@ rtl/core/wce_queue.sv @@
// ----------------------------------------------------------------------------
// wce_queue
// Small first-in first-out buffer of finished column envelopes.
// ----------------------------------------------------------------------------
module wce_queue #(
    parameter int WIDTH = 45,
    parameter int DEPTH = wce_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ rtl/core/wce_back.sv @@
// ----------------------------------------------------------------------------
// wce_back
// Row mapper: scales max then min by the gain, maps each to a pixel row of
// the odd draw height through one shared multiply path, and holds the
// finished result until it is taken.
// ----------------------------------------------------------------------------
module wce_back #(
    parameter int SAMPLE_BITS = wce_pkg::SAMPLE_BITS_DEF,
    parameter int COLUMN_BITS = wce_pkg::COLUMN_BITS_DEF,
    parameter int ROW_BITS    = wce_pkg::ROW_BITS_DEF,
    parameter int ITEM_W      = 2 * SAMPLE_BITS + 1 + COLUMN_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wce_pkg::cfg_t          cfg,
    output logic                   q_pop,
    input  logic                   q_empty,
    input  logic [ITEM_W-1:0]      q_data,
    input  logic                   pop,
    output logic                   empty,
    output logic [COLUMN_BITS-1:0] column,
    output logic [ROW_BITS-1:0]    upper_row,
    output logic [ROW_BITS-1:0]    lower_row,
    output logic                   clipped
);
    import wce_pkg::*;

    localparam int PW = SAMPLE_BITS + 17;
    localparam int DW = PW + 1;
    localparam int XW = DW + ROW_BITS + 1;
    localparam int SH = SAMPLE_BITS + 11;
    localparam int HW = (ROW_BITS > TH_W) ? ROW_BITS : TH_W;

    localparam logic signed [DW-1:0] ONE =
        {{(DW-SAMPLE_BITS-11){1'b0}}, 1'b1, {(SAMPLE_BITS+10){1'b0}}};
    localparam logic signed [XW-1:0] ROUND = {{(XW-SH){1'b0}}, {SH{1'b1}}};
    localparam logic [HW-1:0] HMAX = HW'((64'd1 << ROW_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROD,
        S_SPAN,
        S_ROW
    } state_t;

    state_t                        state_reg;
    logic                          sel_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg, min_reg, operand;
    logic                          clip_item_reg;
    logic [COLUMN_BITS-1:0]        col_item_reg;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [DW-1:0]          diff;
    logic signed [XW-1:0]          span_reg, span_next, floor_v, ceil_v, row_raw, h_x;
    logic [ROW_BITS-1:0]           row, upper_tmp_reg;
    logic [HW-1:0]                 th_w, th_odd, h_full;
    logic [ROW_BITS-1:0]           h;
    logic                          out_valid_reg, out_free, out_write;
    logic [COLUMN_BITS-1:0]        col_out_reg;
    logic [ROW_BITS-1:0]           upper_out_reg, lower_out_reg;
    logic                          clip_out_reg;

    // Draw height: drop one if even and nonzero, limit to the row range.
    assign th_w   = HW'(cfg.track_height);
    assign th_odd = (th_w != '0 && !th_w[0]) ? th_w - HW'(1) : th_w;
    assign h_full = (th_odd > HMAX) ? HMAX : th_odd;
    assign h      = h_full[ROW_BITS-1:0];
    assign h_x    = $signed({{(XW-ROW_BITS){1'b0}}, h});

    assign operand   = sel_reg ? min_reg : max_reg;
    assign prod_next = operand * $signed({1'b0, cfg.gain});
    assign diff      = ONE - prod_reg;
    assign span_next = $signed({1'b0, h}) * diff;

    // Upper rounds down, lower rounds up.
    assign floor_v = span_reg >>> SH;
    assign ceil_v  = (span_reg + ROUND) >>> SH;
    assign row_raw = sel_reg ? ceil_v : floor_v;

    always_comb
    begin
        if (row_raw < 0)
        begin
            row = '0;
        end
        else if (row_raw > h_x)
        begin
            row = h;
        end
        else
        begin
            row = row_raw[ROW_BITS-1:0];
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_free  = !out_valid_reg || pop;
    assign out_write = (state_reg == S_ROW) && sel_reg && out_free;

    assign empty     = !out_valid_reg;
    assign column    = col_out_reg;
    assign upper_row = upper_out_reg;
    assign lower_row = lower_out_reg;
    assign clipped   = clip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            max_reg       <= '0;
            min_reg       <= '0;
            clip_item_reg <= 1'b0;
            col_item_reg  <= '0;
            prod_reg      <= '0;
            span_reg      <= '0;
            upper_tmp_reg <= '0;
            out_valid_reg <= 1'b0;
            col_out_reg   <= '0;
            upper_out_reg <= '0;
            lower_out_reg <= '0;
            clip_out_reg  <= 1'b0;
        end
        else
        begin
            // Drop the taken result unless a new one replaces it now.
            if (pop && out_valid_reg && !out_write)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        max_reg       <= q_data[SAMPLE_BITS-1:0];
                        min_reg       <= q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
                        clip_item_reg <= q_data[2*SAMPLE_BITS];
                        col_item_reg  <= q_data[ITEM_W-1:2*SAMPLE_BITS+1];
                        sel_reg       <= 1'b0;
                        state_reg     <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    span_reg  <= span_next;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    if (!sel_reg)
                    begin
                        upper_tmp_reg <= row;
                        sel_reg       <= 1'b1;
                        state_reg     <= S_PROD;
                    end
                    else if (out_write)
                    begin
                        col_out_reg   <= col_item_reg;
                        upper_out_reg <= upper_tmp_reg;
                        lower_out_reg <= row;
                        clip_out_reg  <= clip_item_reg && cfg.show_clipping;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && !q_empty)
        else $error("column queue read outside idle");

    a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (upper_out_reg <= lower_out_reg) && (lower_out_reg <= h))
        else $error("envelope rows out of order or beyond draw height");

    a_result_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ROW && sel_reg))
        else $error("result loaded outside the lower row step");

endmodule

@@ tb/wce_checker.sv @@
// ----------------------------------------------------------------------------
// wce_checker
// Watches the sample, result and register channels of the envelope unit and
// predicts every column envelope from an internal copy of the register file
// and the accumulator state. Each popped result is compared field by field
// with the oldest prediction, and register reads are checked against the copy.
// ----------------------------------------------------------------------------
module wce_checker
    import wce_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    input  logic [DATA_W-1:0]             prdata,
    input  logic                          pready,
    input  logic                          push,
    input  logic                          full,
    input  logic signed [SAMPLE_BITS_DEF-1:0] sample,
    input  logic                          pop,
    input  logic                          empty,
    input  logic [COLUMN_BITS_DEF-1:0]    column,
    input  logic [ROW_BITS_DEF-1:0]       upper_row,
    input  logic [ROW_BITS_DEF-1:0]       lower_row,
    input  logic                          clipped,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COLUMN_BITS_DEF-1:0] column;
        logic [ROW_BITS_DEF-1:0]    upper_row;
        logic [ROW_BITS_DEF-1:0]    lower_row;
        logic                       clipped;
    } envelope_t;

    cfg_t                              regs;
    logic signed [SAMPLE_BITS_DEF-1:0] peak_hi;
    logic signed [SAMPLE_BITS_DEF-1:0] peak_lo;
    logic                              clip_seen;
    logic [SPC_W-1:0]                  run_count;
    logic [COLUMN_BITS_DEF-1:0]        column_idx;
    envelope_t                         expected_columns[$];
    int                                reported;

    task automatic note_mismatch(input string msg);
        errors++;
        if (reported < 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
            reported++;
        end
    endtask

    function automatic longint div_down(input longint num, input longint den);
        longint q;
        q = num / den;
        if (num % den != 0 && num < 0)
            q -= 1;
        return q;
    endfunction

    function automatic longint div_up(input longint num, input longint den);
        longint q;
        q = num / den;
        if (num % den != 0 && num > 0)
            q += 1;
        return q;
    endfunction

    function automatic longint fit_rows(input longint v, input longint h);
        if (v < 0)
            return 0;
        if (v > h)
            return h;
        return v;
    endfunction

    // Fold one sample into the running envelope; queue a column at run end.
    task automatic fold_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s);
        longint      full_scale;
        longint      unity;
        longint      h;
        longint      p_hi;
        longint      p_lo;
        longint      up;
        longint      lo;
        int unsigned run_len;
        int unsigned width;
        int unsigned next_col;
        envelope_t   e;
        full_scale = 64'sd1 <<< (SAMPLE_BITS_DEF - 2);
        run_len = (regs.samples_per_column == 0) ? 1 : regs.samples_per_column;
        if (run_count == 0)
        begin
            peak_hi = s;
            peak_lo = s;
            clip_seen = 1'b0;
        end
        else
        begin
            if (s > peak_hi)
                peak_hi = s;
            if (s < peak_lo)
                peak_lo = s;
        end
        if (s >= full_scale || s <= -full_scale)
            clip_seen = 1'b1;
        run_count = run_count + 1'b1;
        if (run_count != 0 && run_count < run_len)
            return;

        unity = full_scale * 4096;
        h = regs.track_height;
        if (h % 2 == 0 && h > 0)
            h -= 1;
        if (h > (64'sd1 <<< ROW_BITS_DEF) - 1)
            h = (64'sd1 <<< ROW_BITS_DEF) - 1;
        p_hi = longint'(peak_hi) * longint'(regs.gain);
        p_lo = longint'(peak_lo) * longint'(regs.gain);
        up = fit_rows(div_down(h * (unity - p_hi), 2 * unity), h);
        lo = fit_rows(div_up(h * (unity - p_lo), 2 * unity), h);

        e.column    = column_idx;
        e.upper_row = up[ROW_BITS_DEF-1:0];
        e.lower_row = lo[ROW_BITS_DEF-1:0];
        e.clipped   = clip_seen & regs.show_clipping;
        expected_columns.push_back(e);

        // Wrap at the screen width or at the column range, whichever is hit first.
        width = (regs.screen_width == 0) ? 1 : regs.screen_width;
        next_col = column_idx + 1;
        if (next_col >= width || next_col >= (1 << COLUMN_BITS_DEF))
            next_col = 0;
        column_idx = next_col[COLUMN_BITS_DEF-1:0];
        run_count = '0;
        clip_seen = 1'b0;
    endtask

    always @(posedge clk)
    begin : monitor
        envelope_t         e;
        logic [DATA_W-1:0] reg_value;
        logic              known;
        if (!rst_n)
        begin
            regs = '{SPC_RST, SW_RST, TH_RST, GAIN_RST, SHOW_RST};
            peak_hi = '0;
            peak_lo = '0;
            clip_seen = 1'b0;
            run_count = '0;
            column_idx = '0;
            expected_columns.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_columns.size() == 0)
                    note_mismatch($sformatf("unexpected column %0d rows %0d..%0d clip %0b",
                                            column, upper_row, lower_row, clipped));
                else
                begin
                    e = expected_columns.pop_front();
                    if (column !== e.column || upper_row !== e.upper_row ||
                        lower_row !== e.lower_row || clipped !== e.clipped)
                        note_mismatch($sformatf(
                            "column %0d/%0d upper %0d/%0d lower %0d/%0d clip %0b/%0b (exp/got)",
                            e.column, column, e.upper_row, upper_row,
                            e.lower_row, lower_row, e.clipped, clipped));
                end
            end

            if (push && !full)
                fold_sample(sample);

            if (psel && penable && pready)
            begin
                known = 1'b1;
                reg_value = '0;
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[ADDR_W-1:2]))
                        REG_SPC:  regs.samples_per_column = pwdata[SPC_W-1:0];
                        REG_SW:   regs.screen_width       = pwdata[SW_W-1:0];
                        REG_TH:   regs.track_height       = pwdata[TH_W-1:0];
                        REG_GAIN: regs.gain               = pwdata[GAIN_W-1:0];
                        REG_SHOW: regs.show_clipping      = pwdata[0];
                        default:  ;
                    endcase
                end
                else
                begin
                    case (reg_idx_t'(paddr[ADDR_W-1:2]))
                        REG_SPC:  reg_value = DATA_W'(regs.samples_per_column);
                        REG_SW:   reg_value = DATA_W'(regs.screen_width);
                        REG_TH:   reg_value = DATA_W'(regs.track_height);
                        REG_GAIN: reg_value = DATA_W'(regs.gain);
                        REG_SHOW: reg_value = DATA_W'(regs.show_clipping);
                        default:  known = 1'b0;
                    endcase
                    if (known && prdata !== reg_value)
                        note_mismatch($sformatf("register read at %0d: exp %0d got %0d",
                                                paddr, reg_value, prdata));
                end
            end
        end
        pending = expected_columns.size();
    end

endmodule

@@ tb/tb_waveform_column_envelope_unit.sv @@
// ----------------------------------------------------------------------------
// tb_waveform_column_envelope_unit
// Drives samples, register transfers and result pops into the envelope unit.
// A directed pass covers sample extremes and register corner settings, then
// random streams run under changing settings and idling patterns, including
// a long result stall that backs the unit up. Checking is done by wce_checker.
// ----------------------------------------------------------------------------
module tb_waveform_column_envelope_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wce_pkg::*;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ADDR_W-1:0]                 paddr;
    logic [DATA_W-1:0]                 pwdata;
    logic [DATA_W-1:0]                 prdata;
    logic                              pready;
    logic                              push;
    logic                              full;
    logic signed [SAMPLE_BITS_DEF-1:0] sample;
    logic                              pop;
    logic                              empty;
    logic [COLUMN_BITS_DEF-1:0]        column;
    logic [ROW_BITS_DEF-1:0]           upper_row;
    logic [ROW_BITS_DEF-1:0]           lower_row;
    logic                              clipped;
    int                                errors;
    int                                pending;
    int                                sender_idle_pct;
    int                                receiver_idle_pct;
    bit                                hold_request;

    waveform_column_envelope_unit u_top (.*);

    wce_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // One register transfer: setup phase, access phase, then an idle gap.
    task automatic cfg_access(input reg_idx_t idx, input logic write,
                              input int unsigned value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        sample = s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain all results, then let the unit idle; a partial run stays in the intake.
    task automatic settle();
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] rand_sample();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:
            begin
                v = 16384 + $urandom_range(4) - 2;
                if ($urandom_range(1))
                    v = -v;
            end
            6: v = $urandom_range(1) ? 32767 : -32768;
            default: v = $urandom_range(24000) - 12000;
        endcase
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    task automatic shuffle_config();
        int unsigned v;
        if ($urandom_range(2) != 0)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: v = $urandom_range(8, 1);
                6, 7: v = $urandom_range(64, 9);
                8: v = 0;
                default: v = $urandom_range(300, 100);
            endcase
            cfg_access(REG_SPC, 1'b1, v);
        end
        if ($urandom_range(1))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: v = $urandom_range(40, 1);
                6: v = 0;
                7: v = 4096;
                8: v = 8191;
                default: v = $urandom_range(8191);
            endcase
            cfg_access(REG_SW, 1'b1, v);
        end
        if ($urandom_range(1))
        begin
            case ($urandom_range(7))
                0: v = 0;
                1: v = $urandom_range(4, 1);
                2: v = 4095;
                3: v = 2048;
                default: v = $urandom_range(4095);
            endcase
            cfg_access(REG_TH, 1'b1, v);
        end
        if ($urandom_range(1))
        begin
            case ($urandom_range(5))
                0: v = 0;
                1: v = 65535;
                2: v = 4096;
                3: v = $urandom_range(8192, 2048);
                default: v = $urandom_range(65535);
            endcase
            cfg_access(REG_GAIN, 1'b1, v);
        end
        if ($urandom_range(1))
            cfg_access(REG_SHOW, 1'b1, $urandom_range(1));
        cfg_access(reg_idx_t'($urandom_range(4)), 1'b0, 0);
    endtask

    initial
    begin : receiver
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // Hold off long enough for the unit to fill and stall its intake.
                hold_request = 1'b0;
                pop = 1'b0;
                repeat (400) @(negedge clk);
            end
            pop = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_BITS_DEF-1:0] corner_samples[10];
        int                                n;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        sample = '0;
        hold_request = 1'b0;
        sender_idle_pct = 35;
        receiver_idle_pct = 47;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 5; i++)
            cfg_access(reg_idx_t'(i), 1'b0, 0);

        // Sample extremes at reset settings: one column per sample.
        corner_samples = '{16'sh7FFF, -16'sh8000, 16'sd16384, -16'sd16384, 16'sd16383,
                           -16'sd16383, 16'sd0, -16'sd1, 16'sh5555, -16'sh5556};
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        // Column beyond a lowered width: held once, then back to zero.
        settle();
        cfg_access(REG_SW, 1'b1, 4);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);

        // Zero run length, zero width, zero height, top gain, clip flag hidden.
        settle();
        cfg_access(REG_SPC, 1'b1, 0);
        cfg_access(REG_SW, 1'b1, 0);
        cfg_access(REG_TH, 1'b1, 0);
        cfg_access(REG_GAIN, 1'b1, 65535);
        cfg_access(REG_SHOW, 1'b1, 0);
        for (int i = 0; i < 5; i++)
            cfg_access(reg_idx_t'(i), 1'b0, 0);
        send_sample(16'sd16384);
        send_sample(-16'sh8000);
        send_sample(16'sd5);

        // Oversized height, zero gain, short runs with a partial run left over.
        settle();
        cfg_access(REG_TH, 1'b1, 4095);
        cfg_access(REG_GAIN, 1'b1, 0);
        cfg_access(REG_SHOW, 1'b1, 1);
        cfg_access(REG_SPC, 1'b1, 3);
        cfg_access(REG_SW, 1'b1, 5);
        send_sample(-16'sd16384);
        send_sample(16'sd200);
        send_sample(16'sd300);
        send_sample(16'sh7FFF);
        send_sample(16'sd0);
        send_sample(-16'sd50);
        send_sample(16'sd16383);

        // Longest run, then lower the run length below the count reached.
        settle();
        cfg_access(REG_TH, 1'b1, 2048);
        cfg_access(REG_GAIN, 1'b1, 4096);
        cfg_access(REG_SPC, 1'b1, 65535);
        cfg_access(REG_SPC, 1'b0, 0);
        repeat (4) send_sample(rand_sample());
        settle();
        cfg_access(REG_SPC, 1'b1, 2);
        send_sample(-16'sd7000);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_idle_pct = 35;
                    receiver_idle_pct = 47;
                end
                1:
                begin
                    sender_idle_pct = 47;
                    receiver_idle_pct = 35;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 10; seg++)
            begin
                settle();
                shuffle_config();
                if (mode == 0 && seg == 0)
                begin
                    cfg_access(REG_SPC, 1'b1, 1);
                    hold_request = 1'b1;
                end
                n = $urandom_range(65, 30);
                repeat (n) send_sample(rand_sample());
            end
        end

        // Width above the column range at full draw height.
        settle();
        cfg_access(REG_SPC, 1'b1, 1);
        cfg_access(REG_SW, 1'b1, 8191);
        cfg_access(REG_TH, 1'b1, 2047);
        repeat (30) send_sample(rand_sample());

        push = 1'b0;
        n = 0;
        while (pending != 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (30) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
